// ===== rtl/core/odd_only_eratosthenes_sieve_macros.svh =====
// Assertion macros shared by the sieve RTL.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef ODD_ONLY_ERATOSTHENES_SIEVE_MACROS_SVH
`define ODD_ONLY_ERATOSTHENES_SIEVE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/oes_pkg.sv =====
// Package for the odd-only prime sieve: sizes, codes, control structs, popcount.
// No dependencies.
package oes_pkg;

	localparam int unsigned MAX_LIMIT = 65536;
	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned NUM_WORDS = MAX_LIMIT / 2 / WORD_BITS;
	localparam int unsigned ADDR_W    = $clog2(NUM_WORDS);
	localparam int unsigned BIT_W     = $clog2(WORD_BITS);
	localparam int unsigned POP_W     = $clog2(WORD_BITS + 1);
	localparam int unsigned LIM_W     = 17;
	localparam int unsigned NUM_W     = 16;
	localparam int unsigned CNT_W     = 13;
	// i = (p-1)/2 of the candidate prime; p*p < 2^16 keeps i at or below 127
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(MAX_LIMIT);
	localparam logic [IDX_W-1:0] I_INIT      = IDX_W'(1);
	localparam logic [LIM_W-1:0] SQ_INIT     = LIM_W'(9);

	localparam logic       FUNC_RUN  = 1'b0;
	localparam logic       FUNC_TEST = 1'b1;
	localparam logic       REG_LIMIT = 1'b0;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_RANGE     = 2'd1;
	localparam logic [1:0] STATUS_NOT_READY = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_P_CHECK,
		ST_P_WAIT,
		ST_CLR_CHECK,
		ST_CLR_WRITE,
		ST_NEXT_I,
		ST_NEXT_SQ,
		ST_COUNT,
		ST_CDRAIN1,
		ST_CDRAIN2,
		ST_FINISH,
		ST_TEST_WAIT
	} state_t;

	typedef enum logic [1:0] {
		ALU_NONE,
		ALU_INC_I,
		ALU_ADD_SQ,
		ALU_ADD_J
	} alu_op_t;

	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_FILL,
		MEM_RD_P,
		MEM_RD_J,
		MEM_WR_J,
		MEM_RD_CNT,
		MEM_RD_Q
	} mem_op_t;

	typedef struct packed {
		alu_op_t alu_op;
		mem_op_t mem_op;
		logic    init_run;
		logic    j_load;
		logic    res_test;
		logic    res_run;
	} ctrl_t;

	typedef struct packed {
		logic sq_lt_lim;
		logic j_lt_lim;
		logic w_last;
		logic p_bit;
		logic q_bit;
	} stat_t;

	function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
		logic [POP_W-1:0] n;
		n = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			n = n + POP_W'(w[k]);
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/odd_only_eratosthenes_sieve.sv =====
// Top level of the odd-only prime sieve: command port, config port, result regs.
// Depends on oes_pkg, oes_seq, oes_dpath and the assertion macros header.
//
// Usage:
//   An item is taken when start is high and busy is low. func = 0 runs the sieve
//   over all numbers below limit_value; func = 1 tests query_number.
//   Each item yields one result transfer: is_prime, prime_count and status are
//   valid for exactly the one cycle in which result_strobe is high. The receiver
//   cannot stall, so results are never held back.
//   A test that needs no bitmap lookup (not sieved, out of range, even) strobes in the
//   cycle after it is taken. One that reads the bitmap issues the read on the single
//   bitmap read port as it is taken, then passes ST_TEST_WAIT and the strobe register.
//   A run fills all 512 bitmap words, then reads the bit of each odd p with p*p below the limit;
//   a p still marked prime clears each multiple with a read and a write until a check ends the
//   sweep, then i and the square step p. A closing check, a count read of every word, ST_CDRAIN1,
//   ST_CDRAIN2 and ST_FINISH follow. At limit 65536 the marking loop through the shared adder dominates.
//   limit_value lives at byte address 0 of the APB port; writing it clears the
//   sieved flag, so tests report not ready until the next run. Write it only idle.
//   Reset: limit 65536, nothing sieved, internal prime count 0; the result payload and
//   the bitmap are not cleared, every run rewrites the bitmap before use.
`include "odd_only_eratosthenes_sieve_macros.svh"

module odd_only_eratosthenes_sieve (
	input  logic                        clk,
	input  logic                        arst_n,
	// command channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [oes_pkg::NUM_W-1:0]   query_number,
	// result channel
	output logic                        result_strobe,
	output logic                        is_prime,
	output logic [oes_pkg::CNT_W-1:0]   prime_count,
	output logic [1:0]                  status,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [oes_pkg::PADDR_W-1:0] paddr,
	input  logic [oes_pkg::PDATA_W-1:0] pwdata,
	output logic [oes_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import oes_pkg::*;

	logic [LIM_W-1:0] limit_q;
	logic [LIM_W-1:0] lim_eff;
	logic             done_q;
	logic             cfg_wr;
	logic             accept;
	logic             need_rd;
	logic             q_in_range;
	logic             direct_res;
	ctrl_t            ctrl;
	stat_t            stat;
	logic [CNT_W-1:0] found_primes;

	// Configuration: single register, decode on the word address bit only
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT);
	assign prdata = (paddr[2] == REG_LIMIT) ? PDATA_W'(limit_q) : '0;

	// Saturate the limit to the bitmap's reach
	assign lim_eff = (limit_q > LIMIT_RESET) ? LIMIT_RESET : limit_q;

	// A test needs the bitmap only for an odd, in-range number after a run
	assign accept     = start && !busy;
	assign q_in_range = (LIM_W'(query_number) < lim_eff);
	assign need_rd    = (func == FUNC_TEST) && done_q && q_in_range && query_number[0];
	assign direct_res = accept && (func == FUNC_TEST) && !need_rd;

	oes_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.need_rd (need_rd),
		.stat    (stat),
		.ctrl    (ctrl),
		.busy    (busy)
	);

	oes_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.lim          (lim_eff),
		.query_number (query_number),
		.stat         (stat),
		.found_primes (found_primes)
	);

	// Control state: limit register, sieved flag, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q       <= LIMIT_RESET;
			done_q        <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= ctrl.res_run || ctrl.res_test || direct_res;
			if (cfg_wr) begin
				limit_q <= pwdata[LIM_W-1:0];
				done_q  <= 1'b0;
			end else if (ctrl.res_run) begin
				done_q <= 1'b1;
			end
		end
	end

	// Result payload: hold between transfers, update on each result
	always_ff @(posedge clk) begin
		if (ctrl.res_run) begin
			is_prime    <= 1'b0;
			prime_count <= found_primes;
			status      <= STATUS_OK;
		end else if (ctrl.res_test) begin
			is_prime    <= stat.q_bit;
			prime_count <= found_primes;
			status      <= STATUS_OK;
		end else if (direct_res) begin
			// only 2 is prime among the numbers answered without a lookup
			is_prime    <= done_q && q_in_range && (query_number == NUM_W'(2));
			prime_count <= found_primes;
			if (!done_q) begin
				status <= STATUS_NOT_READY;
			end else if (!q_in_range) begin
				status <= STATUS_RANGE;
			end else begin
				status <= STATUS_OK;
			end
		end
	end

	`OES_ASSERT_SAME(a_done_with_result, $rose(done_q), result_strobe,
		"sieved flag set without a run result")
	`OES_ASSERT_NEXT(a_run_goes_busy, start && !busy && func == FUNC_RUN, busy,
		"run transfer accepted but block not busy")
	`OES_ASSERT_SAME(a_not_ready_unsieved, result_strobe && status == STATUS_NOT_READY,
		!done_q, "not-ready status while the sieve is done")

endmodule

// ===== rtl/core/oes_bitmap_ram.sv =====
// Bitmap store: one write port, one read port, registered read data.
// Depends on oes_pkg.
module oes_bitmap_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [oes_pkg::ADDR_W-1:0]    waddr,
	input  logic [oes_pkg::WORD_BITS-1:0] wdata,
	input  logic                         re,
	input  logic [oes_pkg::ADDR_W-1:0]    raddr,
	output logic [oes_pkg::WORD_BITS-1:0] rdata
);
	import oes_pkg::*;

	logic [WORD_BITS-1:0] mem_q [NUM_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/oes_dpath.sv =====
// Sieve datapath: shared adder, loop registers, bitmap addressing, counting pipe.
// Depends on oes_pkg and oes_bitmap_ram.
module oes_dpath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  oes_pkg::ctrl_t            ctrl,
	input  logic [oes_pkg::LIM_W-1:0] lim,
	input  logic [oes_pkg::NUM_W-1:0] query_number,
	output oes_pkg::stat_t            stat,
	output logic [oes_pkg::CNT_W-1:0] found_primes
);
	import oes_pkg::*;

	logic [IDX_W-1:0]     i_q;
	logic [LIM_W-1:0]     sq_q;
	logic [LIM_W-1:0]     j_q;
	logic [ADDR_W-1:0]    w_q;
	logic [BIT_W-1:0]     qbit_q;
	logic [CNT_W-1:0]     acc_q;
	logic                 rd_cnt_s1;
	logic [ADDR_W-1:0]    w_s1;
	logic [POP_W-1:0]     pop_s2;
	logic                 pop_vld_s2;

	logic [LIM_W-1:0]     opa;
	logic [LIM_W-1:0]     opb;
	logic [LIM_W-1:0]     sum;

	logic                 we;
	logic                 re;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic [WORD_BITS-1:0] wdata;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] cnt_mask;

	logic [LIM_W-BIT_W-2:0] kword;
	logic [BIT_W-1:0]       kbit;

	// Shared adder: one operation per cycle, chosen by the sequencer
	always_comb begin
		case (ctrl.alu_op)
			ALU_INC_I: begin
				opa = LIM_W'(i_q);
				opb = LIM_W'(1);
			end
			ALU_ADD_SQ: begin
				// (p+2)^2 = p^2 + 8*(i+1), applied after i has advanced
				opa = sq_q;
				opb = LIM_W'({i_q, 3'b000});
			end
			ALU_ADD_J: begin
				// step to the next odd multiple: 2p = 4i + 2
				opa = j_q;
				opb = LIM_W'({i_q, 2'b10});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		sum = opa + opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= I_INIT;
			sq_q  <= SQ_INIT;
			j_q   <= '0;
			w_q   <= '0;
			acc_q <= '0;
		end else begin
			if (ctrl.init_run) begin
				i_q   <= I_INIT;
				sq_q  <= SQ_INIT;
				w_q   <= '0;
				// count 2 up front when it lies below the limit
				acc_q <= (lim > LIM_W'(2)) ? CNT_W'(1) : CNT_W'(0);
			end else begin
				case (ctrl.alu_op)
					ALU_INC_I:  i_q  <= sum[IDX_W-1:0];
					ALU_ADD_SQ: sq_q <= sum;
					ALU_ADD_J:  j_q  <= sum;
					default:    ;
				endcase
				if (ctrl.j_load) begin
					j_q <= sq_q;
				end
				if (ctrl.mem_op == MEM_FILL || ctrl.mem_op == MEM_RD_CNT) begin
					w_q <= w_q + ADDR_W'(1);
				end
				if (pop_vld_s2) begin
					acc_q <= acc_q + CNT_W'(pop_s2);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_op == MEM_RD_Q) begin
			qbit_q <= query_number[BIT_W:1];
		end
	end

	// Bitmap port muxing; odd n sits at word n[15:7], bit n[6:1]
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = w_q;
		raddr = w_q;
		wdata = '1;
		case (ctrl.mem_op)
			MEM_FILL: begin
				we = 1'b1;
				// clear the bit for 1 while filling word zero
				wdata = (w_q == '0) ? {{(WORD_BITS-1){1'b1}}, 1'b0} : '1;
			end
			MEM_RD_P: begin
				re    = 1'b1;
				raddr = ADDR_W'(i_q >> BIT_W);
			end
			MEM_RD_J: begin
				re    = 1'b1;
				raddr = j_q[NUM_W-1:BIT_W+1];
			end
			MEM_WR_J: begin
				we    = 1'b1;
				waddr = j_q[NUM_W-1:BIT_W+1];
				wdata = rdata & ~(WORD_BITS'(1) << j_q[BIT_W:1]);
			end
			MEM_RD_CNT: begin
				re = 1'b1;
			end
			MEM_RD_Q: begin
				re    = 1'b1;
				raddr = query_number[NUM_W-1:BIT_W+1];
			end
			default: ;
		endcase
	end

	oes_bitmap_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Count pipe: read word, mask bits at or past index lim/2, popcount, accumulate
	assign kword = lim[LIM_W-1:BIT_W+1];
	assign kbit  = lim[BIT_W:1];

	always_comb begin
		if ((LIM_W-BIT_W-1)'(w_s1) < kword) begin
			cnt_mask = '1;
		end else if ((LIM_W-BIT_W-1)'(w_s1) == kword) begin
			cnt_mask = (WORD_BITS'(1) << kbit) - WORD_BITS'(1);
		end else begin
			cnt_mask = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_s1  <= 1'b0;
			pop_vld_s2 <= 1'b0;
		end else begin
			rd_cnt_s1  <= (ctrl.mem_op == MEM_RD_CNT);
			pop_vld_s2 <= rd_cnt_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1   <= w_q;
		pop_s2 <= popcount(rdata & cnt_mask);
	end

	assign stat.sq_lt_lim = (sq_q < lim);
	assign stat.j_lt_lim  = (j_q < lim);
	assign stat.w_last    = &w_q;
	assign stat.p_bit     = rdata[i_q[BIT_W-1:0]];
	assign stat.q_bit     = rdata[qbit_q];
	assign found_primes   = acc_q;

endmodule

// ===== rtl/core/oes_seq.sv =====
// Sieve sequencer: fill, mark multiples, count, and bitmap lookups for tests.
// Depends on oes_pkg and the assertion macros header.
`include "odd_only_eratosthenes_sieve_macros.svh"

module oes_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           func,
	input  logic           need_rd,
	input  oes_pkg::stat_t stat,
	output oes_pkg::ctrl_t ctrl,
	output logic           busy
);
	import oes_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && func == FUNC_RUN) begin
					state_d = ST_FILL;
				end else if (start && need_rd) begin
					state_d = ST_TEST_WAIT;
				end
			end
			ST_FILL:      if (stat.w_last) state_d = ST_P_CHECK;
			ST_P_CHECK:   state_d = stat.sq_lt_lim ? ST_P_WAIT : ST_COUNT;
			ST_P_WAIT:    state_d = stat.p_bit ? ST_CLR_CHECK : ST_NEXT_I;
			ST_CLR_CHECK: state_d = stat.j_lt_lim ? ST_CLR_WRITE : ST_NEXT_I;
			ST_CLR_WRITE: state_d = ST_CLR_CHECK;
			ST_NEXT_I:    state_d = ST_NEXT_SQ;
			ST_NEXT_SQ:   state_d = ST_P_CHECK;
			ST_COUNT:     if (stat.w_last) state_d = ST_CDRAIN1;
			ST_CDRAIN1:   state_d = ST_CDRAIN2;
			ST_CDRAIN2:   state_d = ST_FINISH;
			ST_FINISH:    state_d = ST_IDLE;
			ST_TEST_WAIT: state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '{alu_op: ALU_NONE, mem_op: MEM_NONE, init_run: 1'b0, j_load: 1'b0,
			res_test: 1'b0, res_run: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (start && func == FUNC_RUN) begin
					ctrl.init_run = 1'b1;
				end else if (start && need_rd) begin
					ctrl.mem_op = MEM_RD_Q;
				end
			end
			ST_FILL:      ctrl.mem_op = MEM_FILL;
			ST_P_CHECK:   if (stat.sq_lt_lim) ctrl.mem_op = MEM_RD_P;
			ST_P_WAIT:    ctrl.j_load = stat.p_bit;
			ST_CLR_CHECK: if (stat.j_lt_lim) ctrl.mem_op = MEM_RD_J;
			ST_CLR_WRITE: begin
				ctrl.mem_op = MEM_WR_J;
				ctrl.alu_op = ALU_ADD_J;
			end
			ST_NEXT_I:    ctrl.alu_op = ALU_INC_I;
			ST_NEXT_SQ:   ctrl.alu_op = ALU_ADD_SQ;
			ST_COUNT:     ctrl.mem_op = MEM_RD_CNT;
			ST_FINISH:    ctrl.res_run = 1'b1;
			ST_TEST_WAIT: ctrl.res_test = 1'b1;
			default:      ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`OES_ASSERT_NEXT(a_finish_to_idle, state_q == ST_FINISH, state_q == ST_IDLE,
		"run did not return to idle after finishing")
	`OES_ASSERT_SAME(a_clear_after_read, state_q == ST_CLR_WRITE,
		$past(state_q) == ST_CLR_CHECK, "bitmap clear without a prior read")
	`OES_ASSERT_NEXT(a_count_drains, state_q == ST_COUNT && stat.w_last,
		state_q == ST_CDRAIN1, "count sweep did not drain after the last word")

endmodule

// ===== tb/sv/sieve_result_checker.sv =====
// Result checker for the odd-only prime sieve: tracks the limit register, predicts
// every answer with a sieve of its own and compares it with each result strobe.
// Depends on oes_pkg.
module sieve_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        func,
	input  logic [oes_pkg::NUM_W-1:0]   query_number,
	input  logic                        result_strobe,
	input  logic                        is_prime,
	input  logic [oes_pkg::CNT_W-1:0]   prime_count,
	input  logic [1:0]                  status,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [oes_pkg::PADDR_W-1:0] paddr,
	input  logic [oes_pkg::PDATA_W-1:0] pwdata,
	input  logic [oes_pkg::PDATA_W-1:0] prdata,
	input  logic                        pready,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import oes_pkg::*;

	localparam int unsigned COUNT_CEIL = (1 << CNT_W) - 1;
	localparam int unsigned SHOWN_MAX  = 40;

	typedef struct packed {
		logic             prime;
		logic [CNT_W-1:0] count;
		logic [1:0]       code;
	} answer_t;

	answer_t          answers_due[$];
	logic [LIM_W-1:0] limit_reg;
	logic             sieved;
	logic [CNT_W-1:0] primes_found;
	// one flag per odd number n, at index n >> 1
	bit               odd_is_prime [MAX_LIMIT / 2];
	int               misses = 0;

	assign fail_count = misses;

	task automatic report_mismatch(input string what, input int seen, input int wanted);
		misses++;
		if (misses <= SHOWN_MAX)
			$display("%0t checker: %s: got %0d, expected %0d", $time, what, seen, wanted);
	endtask

	function automatic int unsigned span_of(input logic [LIM_W-1:0] v);
		return (v > LIM_W'(MAX_LIMIT)) ? MAX_LIMIT : int'(v);
	endfunction

	// Mark the odd primes below span and return how many primes lie below it.
	function automatic int unsigned sieve_below(input int unsigned span);
		int unsigned p, j, n, tally;
		foreach (odd_is_prime[k])
			odd_is_prime[k] = 1'b1;
		odd_is_prime[0] = 1'b0;
		for (p = 3; p * p < span; p += 2) begin
			if (odd_is_prime[p >> 1]) begin
				for (j = p * p; j < span; j += 2 * p)
					odd_is_prime[j >> 1] = 1'b0;
			end
		end
		tally = (span > 2) ? 1 : 0;
		for (n = 3; n < span; n += 2) begin
			if (odd_is_prime[n >> 1] && tally < COUNT_CEIL)
				tally++;
		end
		return tally;
	endfunction

	function automatic answer_t answer_for(input logic f, input logic [NUM_W-1:0] q);
		answer_t     a;
		int unsigned span;
		span = span_of(limit_reg);
		a = '{prime: 1'b0, count: '0, code: STATUS_OK};
		if (f == FUNC_RUN) begin
			primes_found = CNT_W'(sieve_below(span));
			sieved = 1'b1;
		end else if (!sieved) begin
			a.code = STATUS_NOT_READY;
		end else if (q >= span) begin
			a.code = STATUS_RANGE;
		end else if (q == 2) begin
			a.prime = 1'b1;
		end else if (q[0]) begin
			a.prime = odd_is_prime[q >> 1];
		end
		a.count = primes_found;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			limit_reg = LIMIT_RESET;
			sieved = 1'b0;
			primes_found = '0;
			answers_due.delete();
			pending <= 0;
		end else begin
			// register port: a write to the limit drops the sieved flag, nothing else
			if (psel && penable && pready && paddr == PADDR_W'({REG_LIMIT, 2'b00})) begin
				if (pwrite) begin
					limit_reg = pwdata[LIM_W-1:0];
					sieved = 1'b0;
				end else if (prdata !== PDATA_W'(limit_reg)) begin
					report_mismatch("limit readback", prdata, limit_reg);
				end
			end
			if (start && !busy)
				answers_due.push_back(answer_for(func, query_number));
			if (result_strobe) begin
				if (answers_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", status, 0);
				end else begin
					want = answers_due.pop_front();
					if (is_prime !== want.prime)
						report_mismatch("is_prime", is_prime, want.prime);
					if (prime_count !== want.count)
						report_mismatch("prime_count", prime_count, want.count);
					if (status !== want.code)
						report_mismatch("status", status, want.code);
				end
			end
			pending <= answers_due.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the odd-only prime sieve testbench: clock, reset, command and register stimulus.
// Depends on oes_pkg, the sieve RTL and sieve_result_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import oes_pkg::*;

	localparam int TOTAL_ITEMS  = 850;
	// no sender gaps over the last stretch of items
	localparam int QUIET_TAIL   = 120;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_NS   = 40_000_000;

	localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'({REG_LIMIT, 2'b00});
	// next word up: no register lives there
	localparam logic [PADDR_W-1:0] SPARE_ADDR = LIMIT_ADDR + PADDR_W'(4);

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               func = FUNC_RUN;
	logic [NUM_W-1:0]   query_number = '0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;

	logic               busy;
	logic               result_strobe;
	logic               is_prime;
	logic [CNT_W-1:0]   prime_count;
	logic [1:0]         status;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int                 fail_count;
	int                 pending;

	int                 n_sent = 0;
	int                 n_runs = 0;
	int                 n_tests = 0;
	int                 n_settings = 0;
	int                 gap_odds = 3;
	logic [LIM_W-1:0]   cur_limit = LIMIT_RESET;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	odd_only_eratosthenes_sieve dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.query_number (query_number),
		.result_strobe(result_strobe),
		.is_prime     (is_prime),
		.prime_count  (prime_count),
		.status       (status),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	sieve_result_checker answer_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.query_number (query_number),
		.result_strobe(result_strobe),
		.is_prime     (is_prime),
		.prime_count  (prime_count),
		.status       (status),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Drop start and hold the command port quiet for a number of cycles.
	task automatic idle_for(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Random sender gap; none in the quiet tail or in gap-free phases.
	task automatic maybe_gap();
		if (n_sent < TOTAL_ITEMS - QUIET_TAIL && gap_odds != 0
				&& $urandom_range(0, 9) < gap_odds)
			idle_for($urandom_range(1, 7));
	endtask

	// Present one command and hold it until the transfer happens. Start stays high
	// on return so back-to-back items never lower and raise it in one step.
	task automatic send_item(input logic f, input logic [NUM_W-1:0] q);
		start <= 1'b1;
		func <= f;
		query_number <= q;
		do @(posedge clk); while (busy);
		n_sent++;
		if (f == FUNC_RUN)
			n_runs++;
		else
			n_tests++;
		maybe_gap();
	endtask

	// Pause the sender until every outstanding answer has come back and the block is idle.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	// One register transfer: setup phase, then access phase until pready, then psel dropped.
	task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		settle();
		reg_access(1'b1, addr, data);
		if (addr == LIMIT_ADDR) begin
			cur_limit = data[LIM_W-1:0];
			n_settings++;
		end
	endtask

	task automatic read_limit();
		settle();
		reg_access(1'b0, LIMIT_ADDR, '0);
	endtask

	function automatic int unsigned span_now();
		return (cur_limit > LIM_W'(MAX_LIMIT)) ? MAX_LIMIT : int'(cur_limit);
	endfunction

	// Mostly well-formed queries below the limit, odd ones above all; the rest probe
	// the limit edge or are pure noise over the whole 16-bit range.
	function automatic logic [NUM_W-1:0] pick_query(input int unsigned span);
		int unsigned roll;
		int          near;
		roll = $urandom_range(0, 99);
		if (span >= 3 && roll < 60)
			return NUM_W'($urandom_range(0, (span - 2) / 2) * 2 + 1);
		if (span >= 3 && roll < 70)
			return NUM_W'($urandom_range(0, (span - 1) / 2) * 2);
		if (roll < 85) begin
			near = int'(span) + int'($urandom_range(0, 4)) - 2;
			if (near < 0)
				near = 0;
			if (near > 65535)
				near = 65535;
			return NUM_W'(near);
		end
		return NUM_W'($urandom());
	endfunction

	task automatic directed_checks();
		logic [NUM_W-1:0] probes [10];
		// edges of the query range, 2, small numbers, prime squares and the top prime
		probes = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd63001,
			16'd65521, 16'd65535, 16'd65534};
		// nothing sieved yet after reset
		send_item(FUNC_TEST, 16'd5);
		// a write to the unmapped word must leave the limit and the flag alone
		write_reg(SPARE_ADDR, 32'd7);
		read_limit();
		send_item(FUNC_TEST, 16'd3);
		// full run at the reset limit
		send_item(FUNC_RUN, 16'hFFFF);
		foreach (probes[k])
			send_item(FUNC_TEST, probes[k]);
		// smallest limit with a prime below it: the count must survive the write, tests go not ready
		write_reg(LIMIT_ADDR, 32'd3);
		send_item(FUNC_TEST, 16'd2);
		send_item(FUNC_RUN, 16'd0);
		send_item(FUNC_TEST, 16'd2);
		send_item(FUNC_TEST, 16'd3);
		send_item(FUNC_TEST, 16'd1);
		// limits below three leave no prime at all
		write_reg(LIMIT_ADDR, 32'd2);
		send_item(FUNC_RUN, 16'd0);
		send_item(FUNC_TEST, 16'd1);
		write_reg(LIMIT_ADDR, 32'd0);
		send_item(FUNC_RUN, 16'd0);
		send_item(FUNC_TEST, 16'd0);
		// 25 must be struck since 5*5 is just below the limit
		write_reg(LIMIT_ADDR, 32'd26);
		send_item(FUNC_RUN, 16'd0);
		send_item(FUNC_TEST, 16'd25);
		// limit above the maximum saturates to a full run
		write_reg(LIMIT_ADDR, 32'h1FFFF);
		read_limit();
		send_item(FUNC_RUN, 16'd0);
		send_item(FUNC_TEST, 16'd65535);
		send_item(FUNC_TEST, 16'd65521);
	endtask

	task automatic random_phase();
		int unsigned      roll;
		logic [LIM_W-1:0] lim;
		logic [PDATA_W-1:0] word;
		gap_odds = $urandom_range(0, 4);
		// new limit for most phases: small ones dominate since a run walks the bitmap
		if ($urandom_range(0, 9) < 8) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				lim = LIM_W'($urandom_range(0, 2));
			else if (roll < 65)
				lim = LIM_W'($urandom_range(3, 600));
			else if (roll < 95)
				lim = LIM_W'($urandom_range(601, 4000));
			else
				lim = LIM_W'($urandom_range(4001, 12000));
			word = PDATA_W'(lim);
			// junk above the register width must be ignored
			if ($urandom_range(0, 3) == 0)
				word[PDATA_W-1:LIM_W] = (PDATA_W - LIM_W)'($urandom());
			write_reg(LIMIT_ADDR, word);
			if ($urandom_range(0, 5) == 0)
				read_limit();
		end
		if ($urandom_range(0, 19) == 0)
			write_reg(SPARE_ADDR, $urandom());
		// a few tests ahead of the run see the not-ready answer when the limit was just written
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 3))
				send_item(FUNC_TEST, pick_query(span_now()));
		end
		if ($urandom_range(0, 9) != 0)
			send_item(FUNC_RUN, NUM_W'($urandom()));
		repeat ($urandom_range(10, 30)) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				send_item(FUNC_RUN, NUM_W'($urandom()));
			else if (roll < 8 && n_sent < TOTAL_ITEMS - QUIET_TAIL)
				settle();
			else
				send_item(FUNC_TEST, pick_query(span_now()));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		while (n_sent < TOTAL_ITEMS)
			random_phase();
		// all stimulus is in: wait out the answers, then idle for DRAIN_CYCLES
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d sieve runs and %0d primality tests over %0d limit settings",
			n_runs, n_tests, n_settings);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog for a block that stops answering or never goes idle.
	initial begin
		#(TIMEOUT_NS);
		$display("watchdog: run did not complete in time, %0d answers outstanding", pending);
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/oes_pkg.sv
rtl/core/oes_bitmap_ram.sv
rtl/core/oes_dpath.sv
rtl/core/oes_seq.sv
rtl/core/odd_only_eratosthenes_sieve.sv
tb/sv/sieve_result_checker.sv
tb/sv/tb_top.sv
